>>> rtl/core/ost_pkg.sv
package ost_pkg;

   localparam int ACTION_W    = 2;
   localparam int REQ_VALUE_W = 16;
   localparam int POSITION_W  = 5;
   localparam int COUNT_W     = 6;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DECIDE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_RESPOND
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic found;
      logic idx_inc;
      logic append;
      logic reject;
      logic shift_rd;
      logic shift_wr;
      logic shrink;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_insert;
      logic is_delete;
      logic scan_end;
      logic hit;
      logic present;
      logic full;
      logic shift_end;
   } dp_status_type;

endpackage

>>> rtl/core/ost_ctrl.sv
module ost_ctrl
   import ost_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctl_cmd_type   cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            // walked past the last member: value is absent
            if (status.scan_end) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (status.hit) begin
               cmd.found = 1'b1;
               state_in  = ST_DECIDE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESPOND;
            if (status.is_insert && !status.present) begin
               if (status.full) begin
                  cmd.reject = 1'b1;
               end else begin
                  cmd.append = 1'b1;
               end
            end else if (status.is_delete && status.present) begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (status.shift_end) begin
               cmd.shrink = 1'b1;
               state_in   = ST_RESPOND;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            // move the later entry down one place and advance
            cmd.shift_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_RESPOND: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/ost_dpath.sv
module ost_dpath
   import ost_pkg::*;
#(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  ctl_cmd_type            cmd,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [REQ_VALUE_W-1:0] req_value,
   output dp_status_type          status,
   output logic                   rsp_present,
   output logic [POSITION_W-1:0]  rsp_position,
   output logic                   rsp_changed,
   output logic                   rsp_full_reject,
   output logic [COUNT_W-1:0]     rsp_count,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [VALUE_WIDTH-1:0] store_ff [CAPACITY];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [VALUE_WIDTH-1:0] key_ff;
   logic [VALUE_WIDTH-1:0] key_in;
   logic [ACTION_W-1:0]    act_ff;
   logic [CNT_W-1:0]       idx_ff;
   logic [CNT_W-1:0]       idx_in;
   logic [CNT_W-1:0]       idx_next;
   logic [IDX_W-1:0]       pos_ff;
   logic [IDX_W-1:0]       pos_in;
   logic                   present_ff;
   logic                   present_in;
   logic                   changed_ff;
   logic                   changed_in;
   logic                   reject_ff;
   logic                   reject_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;

   assign key_in   = VALUE_WIDTH'(req_value);
   assign idx_next = idx_ff + CNT_W'(1);

   always_comb begin
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      present_in = present_ff;
      changed_in = changed_ff;
      reject_in  = reject_ff;
      count_in   = count_ff;
      if (cmd.load) begin
         idx_in     = '0;
         pos_in     = '0;
         present_in = 1'b0;
         changed_in = 1'b0;
         reject_in  = 1'b0;
      end
      if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
      if (cmd.found) begin
         pos_in     = idx_ff[IDX_W-1:0];
         present_in = 1'b1;
      end
      if (cmd.append) begin
         count_in   = count_ff + CNT_W'(1);
         changed_in = 1'b1;
      end
      if (cmd.shrink) begin
         count_in   = count_ff - CNT_W'(1);
         changed_in = 1'b1;
      end
      if (cmd.reject) begin
         reject_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         present_ff <= 1'b0;
         changed_ff <= 1'b0;
         reject_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         present_ff <= present_in;
         changed_ff <= changed_in;
         reject_ff  <= reject_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      if (cmd.load) begin
         key_ff <= key_in;
         act_ff <= req_action;
      end
   end

   // single write port, single registered read port
   assign wr_en   = cmd.append || cmd.shift_wr;
   assign wr_addr = cmd.append ? count_ff[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign wr_data = cmd.append ? key_ff : rd_data_ff;
   assign rd_en   = cmd.scan_rd || cmd.shift_rd;
   assign rd_addr = cmd.shift_rd ? idx_next[IDX_W-1:0] : idx_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign status.is_insert = (act_ff == ACT_INSERT);
   assign status.is_delete = (act_ff == ACT_DELETE);
   assign status.scan_end  = (idx_ff == count_ff);
   assign status.hit       = (rd_data_ff == key_ff);
   assign status.present   = present_ff;
   assign status.full      = (count_ff == CNT_W'(CAPACITY));
   assign status.shift_end = (idx_next == count_ff);

   assign rsp_present     = present_ff;
   assign rsp_position    = POSITION_W'(pos_ff);
   assign rsp_changed     = changed_ff;
   assign rsp_full_reject = reject_ff;
   assign rsp_count       = COUNT_W'(count_ff);
   assign rsp_is_empty    = (count_ff == '0);
   assign rsp_is_full     = (count_ff == CNT_W'(CAPACITY));

endmodule

>>> rtl/core/ordered_set_table_core.sv
// Ordered set table: insert, delete or query one value per beat.
// Each scan step reads one member (ST_SCAN_RD) and compares it with the key
// (ST_SCAN_CMP); a delete then moves each later member down one place, reading
// it (ST_SHIFT_RD) and writing it (ST_SHIFT_WR); the store reads through a registered port.
// Throughput: one item at a time; busy falls the cycle after rsp_strobe.
// Reset: synchronous, empties the set; the store itself is not cleared.
module ordered_set_table_core
   import ost_pkg::*;
#(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [REQ_VALUE_W-1:0] req_value,
   output logic                   rsp_strobe,
   output logic                   rsp_present,
   output logic [POSITION_W-1:0]  rsp_position,
   output logic                   rsp_changed,
   output logic                   rsp_full_reject,
   output logic [COUNT_W-1:0]     rsp_count,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   ost_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ost_dpath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_action      (req_action),
      .req_value       (req_value),
      .status          (status),
      .rsp_present     (rsp_present),
      .rsp_position    (rsp_position),
      .rsp_changed     (rsp_changed),
      .rsp_full_reject (rsp_full_reject),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted beat did not raise busy");

   a_strobe_release: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("busy held after response beat");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_full_reject) |-> (!rsp_changed && !rsp_present && rsp_is_full))
      else $error("refused insert reported a change or a member");

   a_delete_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_changed && rsp_present) |-> !rsp_is_full)
      else $error("set still full after a delete");

endmodule

>>> test/ordered_set_checker.sv
module ordered_set_checker
   import ost_pkg::*;
#(
   parameter int CAPACITY = 32
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [REQ_VALUE_W-1:0] req_value,
   input  logic                   rsp_strobe,
   input  logic                   rsp_present,
   input  logic [POSITION_W-1:0]  rsp_position,
   input  logic                   rsp_changed,
   input  logic                   rsp_full_reject,
   input  logic [COUNT_W-1:0]     rsp_count,
   input  logic                   rsp_is_empty,
   input  logic                   rsp_is_full,
   output int                     errors,
   output int                     pending,
   output int                     beats_checked,
   output int                     refusals_seen,
   output int                     full_seen,
   output int                     empty_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                  present;
      logic [POSITION_W-1:0] position;
      logic                  changed;
      logic                  full_reject;
      logic [COUNT_W-1:0]    count;
      logic                  is_empty;
      logic                  is_full;
   } set_outcome_type;

   logic [REQ_VALUE_W-1:0] member_values [CAPACITY];
   int                     member_total;
   set_outcome_type        pending_outcomes [$];

   task automatic predict_set_op(input logic [ACTION_W-1:0] act,
                                 input logic [REQ_VALUE_W-1:0] val);
      set_outcome_type r;
      int              k;
      int              hit_at;
      logic            hit;
      hit = 1'b0;
      hit_at = 0;
      for (k = 0; k < member_total; k++) begin
         if (!hit && member_values[k] == val) begin
            hit = 1'b1;
            hit_at = k;
         end
      end
      r = '0;
      r.present = hit;
      r.position = POSITION_W'(hit_at);
      if (act == ACT_INSERT) begin
         if (!hit) begin
            if (member_total < CAPACITY) begin
               member_values[member_total] = val;
               member_total++;
               r.changed = 1'b1;
            end else begin
               r.full_reject = 1'b1;
            end
         end
      end else if (act == ACT_DELETE && hit) begin
         // close the gap left by the removed member
         for (k = hit_at; k < member_total - 1; k++)
            member_values[k] = member_values[k + 1];
         member_total--;
         r.changed = 1'b1;
      end
      r.count = COUNT_W'(member_total);
      r.is_empty = (member_total == 0);
      r.is_full = (member_total == CAPACITY);
      pending_outcomes.push_back(r);
   endtask

   task automatic check_beat();
      set_outcome_type want;
      logic            bad;
      if (pending_outcomes.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: result beat with no operation outstanding", $realtime);
      end else begin
         want = pending_outcomes.pop_front();
         beats_checked++;
         if (want.full_reject) refusals_seen++;
         if (want.is_full) full_seen++;
         if (want.is_empty) empty_seen++;
         bad = (rsp_present !== want.present) || (rsp_position !== want.position) ||
               (rsp_changed !== want.changed) || (rsp_full_reject !== want.full_reject) ||
               (rsp_count !== want.count) || (rsp_is_empty !== want.is_empty) ||
               (rsp_is_full !== want.is_full);
         if (bad) begin
            errors++;
            if (errors <= 10) begin
               $write("%0t: mismatch (expected/actual) present %b/%b position %0d/%0d ",
                      $realtime, want.present, rsp_present, want.position, rsp_position);
               $display("changed %b/%b full_reject %b/%b count %0d/%0d empty %b/%b full %b/%b",
                        want.changed, rsp_changed, want.full_reject, rsp_full_reject,
                        want.count, rsp_count, want.is_empty, rsp_is_empty,
                        want.is_full, rsp_is_full);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         member_total = 0;
         pending_outcomes.delete();
         errors = 0;
         beats_checked = 0;
         refusals_seen = 0;
         full_seen = 0;
         empty_seen = 0;
      end else begin
         // a result beat always belongs to an earlier operation, so check first
         if (rsp_strobe === 1'b1) check_beat();
         if (start && !busy) predict_set_op(req_action, req_value);
      end
      pending = pending_outcomes.size();
   end

endmodule

>>> test/tb.sv
module tb;
   import ost_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 32;
   localparam int RANDOM_OPS = 1930;
   localparam int PHASE_LEN = 100;
   localparam int POOL_SIZE = 40;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int TAIL_CYCLES = 160;
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [ACTION_W-1:0]    req_action = ACT_QUERY;
   logic [REQ_VALUE_W-1:0] req_value = '0;
   logic                   rsp_strobe;
   logic                   rsp_present;
   logic [POSITION_W-1:0]  rsp_position;
   logic                   rsp_changed;
   logic                   rsp_full_reject;
   logic [COUNT_W-1:0]     rsp_count;
   logic                   rsp_is_empty;
   logic                   rsp_is_full;

   int errors;
   int pending;
   int beats_checked;
   int refusals_seen;
   int full_seen;
   int empty_seen;
   int ops_sent = 0;
   int cycle_count = 0;

   logic [REQ_VALUE_W-1:0] value_pool [POOL_SIZE];

   always #5 clock = ~clock;

   ordered_set_table_core #(.CAPACITY(CAPACITY), .VALUE_WIDTH(REQ_VALUE_W)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_present(rsp_present), .rsp_position(rsp_position),
      .rsp_changed(rsp_changed), .rsp_full_reject(rsp_full_reject),
      .rsp_count(rsp_count), .rsp_is_empty(rsp_is_empty), .rsp_is_full(rsp_is_full)
   );

   ordered_set_checker #(.CAPACITY(CAPACITY)) checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_present(rsp_present), .rsp_position(rsp_position),
      .rsp_changed(rsp_changed), .rsp_full_reject(rsp_full_reject),
      .rsp_count(rsp_count), .rsp_is_empty(rsp_is_empty), .rsp_is_full(rsp_is_full),
      .errors(errors), .pending(pending), .beats_checked(beats_checked),
      .refusals_seen(refusals_seen), .full_seen(full_seen), .empty_seen(empty_seen)
   );

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [ACTION_W-1:0] ACT_W_RANDOM();
      return ACTION_W'($urandom_range(3));
   endfunction

   // present one operation and hold it until the block takes the beat
   task automatic send_op(input logic [ACTION_W-1:0] act,
                          input logic [REQ_VALUE_W-1:0] val,
                          input bit may_idle);
      bit taken;
      if (may_idle && $urandom_range(99) < 16) begin
         start = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      start = 1'b1;
      req_action = act;
      req_value = val;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      @(negedge clock);
      ops_sent++;
   endtask

   task automatic wait_all_answered();
      start = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int                     n;
      int                     roll;
      int                     phase_kind;
      logic [ACTION_W-1:0]    act;
      logic [REQ_VALUE_W-1:0] val;

      repeat (2) @(negedge clock);
      reset = 1'b0;

      // empty store, duplicate insert, shifting delete, absent delete, spare code
      send_op(ACT_QUERY, 16'h0000, 1'b0);
      send_op(ACT_DELETE, 16'h0000, 1'b0);
      send_op(ACT_INSERT, 16'h0000, 1'b0);
      send_op(ACT_INSERT, 16'hFFFF, 1'b0);
      send_op(ACT_INSERT, 16'h5A5A, 1'b0);
      send_op(ACT_INSERT, 16'h0000, 1'b0);
      send_op(ACT_INSERT, 16'hFFFF, 1'b0);
      send_op(ACT_QUERY, 16'hFFFF, 1'b0);
      send_op(ACT_SPARE, 16'h5A5A, 1'b0);
      send_op(ACT_SPARE, 16'h1234, 1'b0);
      send_op(ACT_DELETE, 16'h0000, 1'b0);
      send_op(ACT_QUERY, 16'hFFFF, 1'b0);
      send_op(ACT_QUERY, 16'h5A5A, 1'b0);
      send_op(ACT_DELETE, 16'h1234, 1'b0);
      send_op(ACT_INSERT, 16'hA5A5, 1'b0);
      send_op(ACT_DELETE, 16'h5A5A, 1'b0);
      send_op(ACT_DELETE, 16'hA5A5, 1'b0);
      send_op(ACT_DELETE, 16'hFFFF, 1'b0);
      send_op(ACT_QUERY, 16'hFFFF, 1'b0);
      send_op(ACT_DELETE, 16'hFFFF, 1'b0);
      wait_all_answered();

      for (n = 0; n < RANDOM_OPS; n++) begin
         phase_kind = (n / PHASE_LEN) % 3;
         // fill, mix, drain; fresh values at the start of each fill
         if (n % PHASE_LEN == 0 && phase_kind == 0)
            for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = REQ_VALUE_W'($urandom);
         if (n == RANDOM_OPS / 2) wait_all_answered();
         roll = $urandom_range(99);
         val = value_pool[$urandom_range(POOL_SIZE - 1)];
         act = ($urandom_range(4) == 0) ? ACT_SPARE : ACT_QUERY;
         if (roll < 10) begin
            act = ACT_W_RANDOM();
            val = REQ_VALUE_W'($urandom);
         end else if (phase_kind == 0) begin
            if (roll < 80) act = ACT_INSERT;
            else if (roll < 90) act = ACT_DELETE;
         end else if (phase_kind == 1) begin
            if (roll < 50) act = ACT_INSERT;
            else if (roll < 75) act = ACT_DELETE;
         end else begin
            if (roll < 20) act = ACT_INSERT;
            else if (roll < 85) act = ACT_DELETE;
         end
         send_op(act, val, !(n >= 600 && n < 1000));
      end

      wait_all_answered();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("Ran %0d set operations, %0d result beats checked; %0d inserts refused",
               ops_sent, beats_checked, refusals_seen);
      $display("Results with the set full: %0d, with the set empty: %0d",
               full_seen, empty_seen);
      if (errors == 0 && pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
